[rtl/fbfl_pkg.sv]
// ----------------------------------------------------------------------------
// fbfl_pkg
// Types and constants for the fixed block free list allocator.
// ----------------------------------------------------------------------------
package fbfl_pkg;

    localparam int SLOT_W   = 8;
    localparam int SIZE_W   = 13;
    localparam int OFFSET_W = 20;

    localparam logic [SIZE_W-1:0] ITEM_SIZE_RESET = 13'd8;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic STAT_DONE      = 1'b0;
    localparam logic STAT_EXHAUSTED = 1'b1;

    typedef struct packed {
        logic              opcode;
        logic [SLOT_W-1:0] slot;
    } t_cmd;

    typedef struct packed {
        logic                status;
        logic [SLOT_W-1:0]   granted_slot;
        logic [OFFSET_W-1:0] byte_offset;
    } t_rsp;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_ALLOC
    } t_state;

endpackage

[rtl/fixed_block_free_list_allocator.sv]
// ----------------------------------------------------------------------------
// fixed_block_free_list_allocator
// LIFO free list of equal-sized slots kept in a link memory with a head
// register; allocate pops the head, free pushes the given slot.
// ----------------------------------------------------------------------------
//  channel   ports                         handshake
//  command   i_cmd                         i_start high, o_busy low
//  result    o_rsp                         o_rsp_valid high for one cycle
//  config    i_cfg_wdata (item_size)       i_cfg_we high
//
//  allocate: accept registers the head slot's link read, then ST_ALLOC registers the result
//  free and exhausted allocate: result in the cycle after accept
//  reset: head at slot 0, link valid bits cleared, item_size 8; no sweep
//  unwritten links read as index plus one; slots at 256 and up never written
//  the receiver cannot stall: each word is shown for exactly one cycle
// ----------------------------------------------------------------------------
module fixed_block_free_list_allocator #(
    parameter int SLOTS = 256
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  fbfl_pkg::t_cmd                 i_cmd,
    output logic                           o_busy,
    output logic                           o_rsp_valid,
    output fbfl_pkg::t_rsp                 o_rsp,
    input  logic                           i_cfg_we,
    input  logic [fbfl_pkg::SIZE_W-1:0]    i_cfg_wdata
);
    import fbfl_pkg::*;

    localparam int LINK_W    = $clog2(SLOTS + 1);
    localparam int MEM_DEPTH = (SLOTS < 256) ? SLOTS : 256;
    localparam int MEM_AW    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam int PROD_W    = (LINK_W + SIZE_W > OFFSET_W) ? (LINK_W + SIZE_W) : OFFSET_W;
    localparam logic [LINK_W-1:0] LINK_NONE = LINK_W'(SLOTS);

    logic [LINK_W-1:0] r_mem [MEM_DEPTH];
    logic [LINK_W-1:0] r_rdata;
    logic [MEM_DEPTH-1:0] r_valid;

    t_state            r_state, n_state;
    logic [LINK_W-1:0] r_head, n_head;
    logic [SIZE_W-1:0] r_item_size;
    logic              r_rsp_valid, n_rsp_valid;
    t_rsp              r_rsp, n_rsp;

    logic              wr_en;
    logic [MEM_AW-1:0] wr_addr;
    logic              rd_en;
    logic [MEM_AW-1:0] head_addr;
    logic              head_in_mem;
    logic [LINK_W-1:0] link;
    logic [PROD_W-1:0] product;
    logic              accept;
    logic              slot_ok;

    assign accept      = i_start && (r_state == ST_IDLE);
    assign head_addr   = r_head[MEM_AW-1:0];
    assign head_in_mem = (32'(r_head) < MEM_DEPTH);
    assign wr_addr     = i_cmd.slot[MEM_AW-1:0];
    assign slot_ok     = (32'(i_cmd.slot) < SLOTS);
    assign link        = (head_in_mem && r_valid[head_addr]) ? r_rdata
                                                             : r_head + LINK_W'(1);
    assign product     = PROD_W'(r_head) * PROD_W'(r_item_size);

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_rsp_valid = 1'b0;
        n_rsp       = r_rsp;
        wr_en       = 1'b0;
        rd_en       = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_rsp.status       = STAT_DONE;
                    n_rsp.granted_slot = '0;
                    n_rsp.byte_offset  = '0;
                    if (i_cmd.opcode == OP_FREE) begin
                        n_rsp_valid = 1'b1;
                        if (slot_ok) begin
                            wr_en  = 1'b1;
                            n_head = LINK_W'(i_cmd.slot);
                        end
                    end else if (r_head == LINK_NONE) begin
                        n_rsp_valid  = 1'b1;
                        n_rsp.status = STAT_EXHAUSTED;
                    end else begin
                        rd_en   = 1'b1;
                        n_state = ST_ALLOC;
                    end
                end
            end
            ST_ALLOC: begin
                n_head             = link;
                n_rsp_valid        = 1'b1;
                n_rsp.status       = STAT_DONE;
                n_rsp.granted_slot = SLOT_W'(r_head);
                n_rsp.byte_offset  = product[OFFSET_W-1:0];
                n_state            = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_head      <= '0;
            r_rsp_valid <= 1'b0;
            r_valid     <= '0;
            r_item_size <= ITEM_SIZE_RESET;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_rsp_valid <= n_rsp_valid;
            if (wr_en) begin
                r_valid[wr_addr] <= 1'b1;
            end
            if (i_cfg_we) begin
                r_item_size <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rsp <= n_rsp;
    end

    // link memory
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= r_head;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rdata <= r_mem[head_addr];
        end
    end

    assign o_busy      = (r_state != ST_IDLE);
    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

`ifndef NO_ASSERTIONS
    a_alloc_answers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ALLOC) |=> (o_rsp_valid && !o_busy))
        else $error("allocate read did not produce a word");

    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> (o_rsp_valid || r_state == ST_ALLOC))
        else $error("accepted command neither answered nor reading");

    a_exhausted_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && o_rsp.status == STAT_EXHAUSTED)
            |-> (o_rsp.granted_slot == '0 && o_rsp.byte_offset == '0))
        else $error("exhausted word carries a slot");

    a_head_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_head) <= SLOTS))
        else $error("head beyond slot range");

    a_alloc_has_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ALLOC) |-> (r_head != LINK_NONE))
        else $error("allocate read on empty list");
`endif

endmodule

[bench/tb_fixed_block_free_list_allocator.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_fixed_block_free_list_allocator
// Self-checking bench for the free list allocator. A short directed table
// opens the run, then biased random traffic drains the pool to exhaustion,
// refills it and adds stray frees. Every response word is compared with a
// local model or a typed row's word, at several item sizes and idle patterns.
// ----------------------------------------------------------------------------
module tb_fixed_block_free_list_allocator;
    import fbfl_pkg::*;

    localparam int SLOTS = 256;
    localparam logic [8:0] LINK_END = 9'(SLOTS);
    localparam t_rsp FREE_ANSWER = '{STAT_DONE, 8'd0, 20'd0};
    localparam t_rsp NOT_TYPED = '0;
    localparam int DIR_ROWS = 19;
    localparam int PHASES = 4;

    typedef struct {
        t_cmd cmd;
        bit   typed;
        t_rsp rsp;
    } t_dir_row;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_start = 1'b0;
    t_cmd              i_cmd = '0;
    logic              o_busy;
    logic              o_rsp_valid;
    t_rsp              o_rsp;
    logic              i_cfg_we = 1'b0;
    logic [SIZE_W-1:0] i_cfg_wdata = '0;

    // free list model
    logic [8:0]        pool_link [SLOTS];
    logic [8:0]        pool_head;
    logic [SIZE_W-1:0] size_model;
    int                out_slots [$];
    t_rsp              pending_rsp [$];

    int  alloc_count = 0;
    int  free_count = 0;
    int  dry_hits = 0;
    int  fail_count = 0;
    int  idle_pct = 0;
    bit  took_cmd = 1'b0;
    bit  typed_en = 1'b0;
    t_rsp typed_rsp = '0;

    // traffic shaping
    bit  draining = 1'b1;
    int  dry_mark = 0;
    int  dry_goal = 3;
    int  hold_floor = 0;

    t_dir_row          dir_rows [DIR_ROWS];
    logic [SIZE_W-1:0] phase_size [PHASES];
    int                phase_idle [PHASES];
    int                phase_len [PHASES];

    fixed_block_free_list_allocator #(
        .SLOTS(SLOTS)
    ) uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_start(i_start),
        .i_cmd(i_cmd),
        .o_busy(o_busy),
        .o_rsp_valid(o_rsp_valid),
        .o_rsp(o_rsp),
        .i_cfg_we(i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    function automatic t_rsp pool_step(input t_cmd c);
        t_rsp        r;
        logic [8:0]  g;
        logic [21:0] prod;
        int          hit;
        r = FREE_ANSWER;
        hit = -1;
        if (c.opcode == OP_ALLOC) begin
            alloc_count++;
            g = pool_head;
            if (g >= LINK_END) begin
                r.status = STAT_EXHAUSTED;
                dry_hits++;
            end else begin
                pool_head = pool_link[g];
                prod = g * size_model;
                r.granted_slot = g[7:0];
                r.byte_offset = prod[19:0];
                out_slots.push_back(int'(g));
            end
        end else begin
            free_count++;
            if (9'(c.slot) < LINK_END) begin
                pool_link[c.slot] = pool_head;
                pool_head = 9'(c.slot);
            end
            for (int k = 0; k < out_slots.size(); k++) begin
                if (hit < 0 && out_slots[k] == int'(c.slot)) hit = k;
            end
            if (hit >= 0) out_slots.delete(hit);
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n) begin
            if (o_rsp_valid) begin
                if (pending_rsp.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected word: status %0d slot %0d offset %0d",
                                 o_rsp.status, o_rsp.granted_slot, o_rsp.byte_offset);
                end else begin
                    want = pending_rsp.pop_front();
                    if (o_rsp.status !== want.status ||
                        o_rsp.granted_slot !== want.granted_slot ||
                        o_rsp.byte_offset !== want.byte_offset) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: status %0d/%0d slot %0d/%0d offset %0d/%0d",
                                     want.status, o_rsp.status,
                                     want.granted_slot, o_rsp.granted_slot,
                                     want.byte_offset, o_rsp.byte_offset);
                    end
                end
            end
            took_cmd <= i_start && !o_busy;
            if (i_start && !o_busy) begin
                want = pool_step(i_cmd);
                if (typed_en) want = typed_rsp;
                pending_rsp.push_back(want);
            end
        end
    end

    task automatic send_cmd(input t_cmd c, input bit t_en, input t_rsp t_val);
        while ($urandom_range(0, 99) < idle_pct) begin
            i_start <= 1'b0;
            @(negedge i_clk);
        end
        typed_en = t_en;
        typed_rsp = t_val;
        i_start <= 1'b1;
        i_cmd <= c;
        do @(negedge i_clk); while (!took_cmd);
    endtask

    task automatic write_item_size(input logic [SIZE_W-1:0] v);
        i_start <= 1'b0;
        do @(negedge i_clk); while (pending_rsp.size() != 0);
        repeat (4) @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        size_model = v;
    endtask

    task automatic send_random(input bit noisy);
        t_cmd c;
        int   pick;
        if (pending_rsp.size() != 0 && $urandom_range(0, 99) < 2) begin
            i_start <= 1'b0;
            do @(negedge i_clk); while (pending_rsp.size() != 0);
        end
        if (draining) begin
            if (dry_hits >= dry_mark + dry_goal) begin
                draining = 1'b0;
                hold_floor = $urandom_range(0, 64);
            end
        end else if (out_slots.size() <= hold_floor) begin
            draining = 1'b1;
            dry_mark = dry_hits;
            dry_goal = $urandom_range(2, 5);
        end
        c.opcode = OP_ALLOC;
        c.slot = 8'($urandom_range(0, 255));
        pick = $urandom_range(0, 99);
        if (noisy && pick < 5) begin
            c.opcode = OP_FREE;
        end else if (out_slots.size() != 0 && pick < (draining ? 3 : 90)) begin
            c.opcode = OP_FREE;
            c.slot = 8'(out_slots[$urandom_range(0, out_slots.size() - 1)]);
        end
        send_cmd(c, 1'b0, NOT_TYPED);
    endtask

    initial begin
        for (int i = 0; i < SLOTS; i++) pool_link[i] = 9'(i + 1);
        pool_link[SLOTS-1] = LINK_END;
        pool_head = '0;
        size_model = ITEM_SIZE_RESET;

        dir_rows = '{
            '{'{OP_ALLOC, 8'h00}, 1'b1, '{STAT_DONE, 8'd0, 20'd0}},
            '{'{OP_ALLOC, 8'hFF}, 1'b1, '{STAT_DONE, 8'd1, 20'd8}},
            '{'{OP_ALLOC, 8'h00}, 1'b1, '{STAT_DONE, 8'd2, 20'd16}},
            '{'{OP_FREE,  8'h01}, 1'b1, FREE_ANSWER},
            '{'{OP_ALLOC, 8'hAA}, 1'b1, '{STAT_DONE, 8'd1, 20'd8}},
            '{'{OP_FREE,  8'h02}, 1'b1, FREE_ANSWER},
            '{'{OP_FREE,  8'h01}, 1'b1, FREE_ANSWER},
            '{'{OP_ALLOC, 8'h55}, 1'b0, NOT_TYPED},
            '{'{OP_ALLOC, 8'h00}, 1'b0, NOT_TYPED},
            '{'{OP_ALLOC, 8'h00}, 1'b0, NOT_TYPED},
            '{'{OP_FREE,  8'h00}, 1'b1, FREE_ANSWER},
            '{'{OP_ALLOC, 8'h00}, 1'b0, NOT_TYPED},
            '{'{OP_FREE,  8'h03}, 1'b0, NOT_TYPED},
            '{'{OP_FREE,  8'h02}, 1'b0, NOT_TYPED},
            '{'{OP_ALLOC, 8'hFF}, 1'b0, NOT_TYPED},
            '{'{OP_ALLOC, 8'h00}, 1'b0, NOT_TYPED},
            '{'{OP_ALLOC, 8'h0F}, 1'b0, NOT_TYPED},
            '{'{OP_FREE,  8'h04}, 1'b0, NOT_TYPED},
            '{'{OP_FREE,  8'h00}, 1'b0, NOT_TYPED}
        };
        phase_size = '{13'd4096, 13'h1FFF, 13'd0, 13'($urandom_range(8, 4096))};
        phase_idle = '{32, 56, 0, 0};
        phase_len = '{150, 150, 75, 75};

        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed words at the reset item size
        idle_pct = 20;
        for (int r = 0; r < DIR_ROWS; r++)
            send_cmd(dir_rows[r].cmd, dir_rows[r].typed, dir_rows[r].rsp);

        // drain to exhaustion and refill; stray frees only in the later phases
        for (int p = 0; p < PHASES; p++) begin
            write_item_size(phase_size[p]);
            idle_pct = phase_idle[p];
            for (int n = 0; n < phase_len[p]; n++) send_random(p >= 2);
        end

        i_start <= 1'b0;
        for (int w = 0; w < 1000 && pending_rsp.size() != 0; w++) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
        if (pending_rsp.size() != 0) begin
            fail_count += pending_rsp.size();
            $display("missing words: %0d", pending_rsp.size());
        end

        $display("run: %0d allocates, %0d frees, %0d answered exhausted",
                 alloc_count, free_count, dry_hits);
        $display("item sizes 8, 4096, 8191, 0 and %0d; %0d failures",
                 phase_size[3], fail_count);
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("timeout with %0d words outstanding", pending_rsp.size());
        $display("status: fail");
        $finish;
    end

endmodule
